// ----- hw/rtl/bns_pkg.sv -----
// Shared types, constants and helpers for the bond neighbor search block.
package bns_pkg;

  localparam int MAX_POINTS   = 4096;
  localparam int MAX_BONDS    = 12;
  localparam int SUBDIVISIONS = 10;
  localparam int FRAC_BITS    = 12;
  localparam int RESULT_SLOTS = 12;
  localparam int BOND_LIMIT   = (MAX_BONDS < RESULT_SLOTS) ? MAX_BONDS : RESULT_SLOTS;

  localparam int AW      = $clog2(MAX_POINTS);
  localparam int CNT_W   = AW + 1;
  localparam int IDX_W   = 12;
  localparam int COORD_W = 20;
  localparam int CUT_W   = 16;
  localparam int MAXN_W  = 4;
  localparam int BOND_W  = $clog2(BOND_LIMIT + 1);
  localparam int DIF_W   = COORD_W + 1;
  localparam int D2_W    = 2 * DIF_W + 2;
  localparam int MID_W   = COORD_W + 8;
  localparam int OFF_W   = 20;
  localparam int SQ_W    = 2 * OFF_W;
  localparam int MK_W    = $clog2(SUBDIVISIONS + 2);
  localparam int NCIRC   = 3;

  // One unit of length in scaled midpoint coordinates
  localparam longint SCALE = longint'(1 << FRAC_BITS) * longint'(2 * SUBDIVISIONS);

  // Forbidden circles (scaled)
  localparam logic signed [MID_W-1:0] CIRC_X [NCIRC] =
    '{MID_W'(40 * SCALE), MID_W'(40 * SCALE), MID_W'(18 * SCALE)};
  localparam logic signed [MID_W-1:0] CIRC_Y [NCIRC] =
    '{MID_W'(14 * SCALE), MID_W'(36 * SCALE), MID_W'(35 * SCALE)};
  localparam logic signed [MID_W-1:0] CIRC_R [NCIRC] =
    '{MID_W'(5 * SCALE), MID_W'(5 * SCALE), MID_W'(4 * SCALE)};
  localparam logic [SQ_W+1:0] CIRC_R2 [NCIRC] =
    '{(SQ_W+2)'(25 * SCALE * SCALE), (SQ_W+2)'(25 * SCALE * SCALE),
      (SQ_W+2)'(16 * SCALE * SCALE)};

  // Notch tip and limits (scaled)
  localparam logic signed [MID_W-1:0] NOTCH_X = MID_W'(32 * SCALE);
  localparam logic signed [MID_W-1:0] NOTCH_Y = MID_W'(25 * SCALE);
  localparam logic signed [MID_W-1:0] NOTCH_U_BIG = MID_W'(2 * SCALE);
  localparam logic [MID_W+4:0] NOTCH_V_LIM = (MID_W+5)'(26 * SCALE);

  // Item modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_IGNORE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_TRUNC  = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_NEAR = 2'd0;
  localparam logic [1:0] REG_FAR  = 2'd1;
  localparam logic [1:0] REG_MAXN = 2'd2;

  typedef struct packed {
    logic [1:0]                 mode;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
    logic [IDX_W-1:0]           query_index;
  } item_t;

  typedef struct packed {
    logic             layer;
    logic [IDX_W-1:0] from_index;
    logic [IDX_W-1:0] to_index;
    logic             has_bond;
    logic             last;
    logic [1:0]       status;
  } result_t;

  typedef struct packed {
    logic [CUT_W-1:0]  near_cutoff;
    logic [CUT_W-1:0]  far_cutoff;
    logic [MAXN_W-1:0] max_neighbors;
  } cfg_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } back_stat_t;

  function automatic logic [2*DIF_W-1:0] sq_dif(input logic signed [DIF_W-1:0] v);
    logic [DIF_W-1:0]   a;
    logic [2*DIF_W-1:0] p;
    a = v[DIF_W-1] ? DIF_W'(-v) : DIF_W'(v);
    p = a * a;
    return p;
  endfunction

  function automatic logic [SQ_W-1:0] sq_off(input logic signed [OFF_W-1:0] v);
    logic [OFF_W-1:0] a;
    logic [SQ_W-1:0]  p;
    a = v[OFF_W-1] ? OFF_W'(-v) : OFF_W'(v);
    p = a * a;
    return p;
  endfunction

endpackage

// ----- hw/rtl/bns_if.sv -----
// Request channel interfaces for input items and result items.
interface bns_in_if;
  import bns_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [IDX_W-1:0]          query_index;
  modport source (output valid, mode, pos_x, pos_y, pos_z, query_index, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, pos_z, query_index, output ready);
endinterface

interface bns_out_if;
  import bns_pkg::*;
  logic             valid;
  logic             ready;
  logic             layer;
  logic [IDX_W-1:0] from_index;
  logic [IDX_W-1:0] to_index;
  logic             has_bond;
  logic             last;
  logic [1:0]       status;
  modport source (output valid, layer, from_index, to_index, has_bond, last, status,
                  input ready);
  modport sink   (input valid, layer, from_index, to_index, has_bond, last, status,
                  output ready);
endinterface

// ----- hw/rtl/bns_cfg.sv -----
// APB configuration registers: near cutoff, far cutoff, bond limit.
module bns_cfg
  import bns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_cutoff   <= CUT_W'(1324);
      cfg.far_cutoff    <= CUT_W'(2293);
      cfg.max_neighbors <= MAXN_W'(12);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_NEAR: cfg.near_cutoff   <= pwdata[CUT_W-1:0];
        REG_FAR:  cfg.far_cutoff    <= pwdata[CUT_W-1:0];
        REG_MAXN: cfg.max_neighbors <= pwdata[MAXN_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_sel)
      REG_NEAR: prdata = 32'(cfg.near_cutoff);
      REG_FAR:  prdata = 32'(cfg.far_cutoff);
      REG_MAXN: prdata = 32'(cfg.max_neighbors);
      default:  prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/bns_front.sv -----
// Front end: accepts items, drops unused modes, queues work for the back end.
module bns_front
  import bns_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  bns_in_if.sink items,
  output logic   q_valid,
  output item_t  q_item,
  input  logic   q_pop
);

  localparam int QD = 2;

  item_t      qbuf [QD];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  item_t      in_item;

  assign in_item = '{mode: items.mode, pos_x: items.pos_x, pos_y: items.pos_y,
                     pos_z: items.pos_z, query_index: items.query_index};

  assign items.ready = (fill != 2'(QD));
  assign push    = items.valid && items.ready && (items.mode != MODE_IGNORE);
  assign q_valid = (fill != 2'd0);
  assign q_item  = qbuf[rd_ptr];

  // queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push)  wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) qbuf[wr_ptr] <= in_item;
  end

endmodule

// ----- hw/rtl/bns_back.sv -----
// Back end: point store, load/clear handling and the query scan sequencer.
module bns_back
  import bns_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  input  logic           q_valid,
  input  item_t          q_item,
  output logic           q_pop,
  bns_out_if.source      results,
  output back_stat_t     stat
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ONE  = 4'd1;
  localparam logic [3:0] S_QA   = 4'd2;
  localparam logic [3:0] S_QB   = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_DIF  = 4'd5;
  localparam logic [3:0] S_SQ   = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_MID  = 4'd8;
  localparam logic [3:0] S_DEC  = 4'd9;
  localparam logic [3:0] S_PEND = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state;

  // point store
  logic [3*COORD_W-1:0] mem [MAX_POINTS];
  logic [3*COORD_W-1:0] rdata;
  logic [AW-1:0]        raddr;
  logic                 we;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  j;
  logic [IDX_W-1:0]  qi;
  logic [BOND_W-1:0] n;
  logic [BOND_W-1:0] limit;
  logic              trunc;
  logic              pend_v;
  logic              pend_layer;
  logic [IDX_W-1:0]  pend_to;
  result_t           single;

  logic signed [COORD_W-1:0] ax, ay, az;
  logic signed [MID_W-1:0]   ax20, ay20;
  logic signed [DIF_W-1:0]   dx, dy, dz;
  logic [2*DIF_W-1:0]        sqx, sqy, sqz;
  logic [D2_W-1:0]           d2;
  logic [2*CUT_W-1:0]        far2, near2;
  logic                      near_hit;

  // midpoint checker
  logic signed [MID_W-1:0] mx, my;
  logic [MK_W-1:0]         mk;
  logic                    blocked;
  logic                    s1_v, s2_v;
  logic signed [OFF_W-1:0] c_ox [NCIRC];
  logic signed [OFF_W-1:0] c_oy [NCIRC];
  logic                    c_in [NCIRC];
  logic [SQ_W-1:0]         c_sx [NCIRC];
  logic [SQ_W-1:0]         c_sy [NCIRC];
  logic                    c_in2 [NCIRC];
  logic signed [OFF_W-1:0] n_u, n_v;
  logic                    n_ok, n_big, n_ok2, n_big2;
  logic [SQ_W-1:0]         n_u2, n_v2;
  logic                    hit;

  logic signed [MID_W-1:0] c_dx [NCIRC];
  logic signed [MID_W-1:0] c_dy [NCIRC];
  logic                    c_bnd [NCIRC];
  logic signed [MID_W-1:0] nu_w, nv_w;
  logic [MID_W-1:0]        nv_abs;
  logic [MID_W+4:0]        nv25;

  logic slot_free;
  logic out_load;
  logic out_v;
  result_t out_r;

  assign slot_free = !out_v || results.ready;
  assign out_load  = slot_free &&
                     ((state == S_ONE) || (state == S_PEND) || (state == S_FIN));
  assign stat.busy  = (state != S_IDLE);
  assign stat.count = count;

  assign results.valid      = out_v;
  assign results.layer      = out_r.layer;
  assign results.from_index = out_r.from_index;
  assign results.to_index   = out_r.to_index;
  assign results.has_bond   = out_r.has_bond;
  assign results.last       = out_r.last;
  assign results.status     = out_r.status;

  assign d2 = D2_W'(sqx) + D2_W'(sqy) + D2_W'(sqz);

  // control decode
  always_comb begin
    q_pop = (state == S_IDLE) && q_valid;
    we    = q_pop && (q_item.mode == MODE_LOAD) && !count[CNT_W-1];
    raddr = (state == S_QA) ? qi[AW-1:0] : j[AW-1:0];
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[count[AW-1:0]] <= {q_item.pos_x, q_item.pos_y, q_item.pos_z};
    rdata <= mem[raddr];
  end

  // midpoint stage 1: region offsets and bounds
  always_comb begin
    for (int c = 0; c < NCIRC; c++) begin
      c_dx[c]  = mx - CIRC_X[c];
      c_dy[c]  = my - CIRC_Y[c];
      c_bnd[c] = (c_dx[c] <= CIRC_R[c]) && (c_dx[c] >= -CIRC_R[c]) &&
                 (c_dy[c] <= CIRC_R[c]) && (c_dy[c] >= -CIRC_R[c]);
    end
    nu_w   = mx - NOTCH_X;
    nv_w   = my - NOTCH_Y;
    nv_abs = nv_w[MID_W-1] ? MID_W'(-nv_w) : MID_W'(nv_w);
    nv25   = (MID_W+5)'(nv_abs) * (MID_W+5)'(25);
  end

  // midpoint stage 3: region hit
  always_comb begin
    hit = n_ok2 && (n_big2 || ((SQ_W+2)'(n_v2) * (SQ_W+2)'(3) <= (SQ_W+2)'(n_u2)));
    for (int c = 0; c < NCIRC; c++) begin
      if (c_in2[c] && ((SQ_W+2)'(c_sx[c]) + (SQ_W+2)'(c_sy[c]) <= CIRC_R2[c])) hit = 1'b1;
    end
  end

  // midpoint pipeline data
  always_ff @(posedge clk) begin
    for (int c = 0; c < NCIRC; c++) begin
      c_ox[c]  <= OFF_W'(c_dx[c]);
      c_oy[c]  <= OFF_W'(c_dy[c]);
      c_in[c]  <= c_bnd[c];
      c_sx[c]  <= sq_off(c_ox[c]);
      c_sy[c]  <= sq_off(c_oy[c]);
      c_in2[c] <= c_in[c];
    end
    n_u    <= OFF_W'(nu_w);
    n_v    <= OFF_W'(nv_w);
    n_ok   <= (nv25 <= NOTCH_V_LIM) && !nu_w[MID_W-1];
    n_big  <= (nu_w >= NOTCH_U_BIG);
    n_u2   <= sq_off(n_u);
    n_v2   <= sq_off(n_v);
    n_ok2  <= n_ok;
    n_big2 <= n_big;
  end

  // distance path data
  always_ff @(posedge clk) begin
    if (state == S_QB) begin
      {ax, ay, az} <= rdata;
      ax20  <= MID_W'(signed'(rdata[3*COORD_W-1 -: COORD_W])) * MID_W'(2 * SUBDIVISIONS);
      ay20  <= MID_W'(signed'(rdata[2*COORD_W-1 -: COORD_W])) * MID_W'(2 * SUBDIVISIONS);
      far2  <= cfg.far_cutoff * cfg.far_cutoff;
      near2 <= cfg.near_cutoff * cfg.near_cutoff;
    end
    if (state == S_DIF) begin
      dx <= DIF_W'(signed'(rdata[3*COORD_W-1 -: COORD_W])) - DIF_W'(ax);
      dy <= DIF_W'(signed'(rdata[2*COORD_W-1 -: COORD_W])) - DIF_W'(ay);
      dz <= DIF_W'(signed'(rdata[COORD_W-1:0])) - DIF_W'(az);
    end
    if (state == S_SQ) begin
      sqx <= sq_dif(dx);
      sqy <= sq_dif(dy);
      sqz <= sq_dif(dz);
      mx  <= ax20 + MID_W'(dx);
      my  <= ay20 + MID_W'(dy);
    end else if (state == S_MID) begin
      mx <= mx + (MID_W'(dx) <<< 1);
      my <= my + (MID_W'(dy) <<< 1);
    end
    if (state == S_CMP) near_hit <= (d2 < D2_W'(near2));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      out_v   <= 1'b0;
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      blocked <= 1'b0;
      pend_v  <= 1'b0;
      trunc   <= 1'b0;
      n       <= '0;
      j       <= '0;
      mk      <= '0;
    end else begin
      // result register: load has priority over drain
      if (out_load) out_v <= 1'b1;
      else if (results.ready) out_v <= 1'b0;
      s1_v <= (state == S_MID) && (mk < MK_W'(SUBDIVISIONS));
      s2_v <= s1_v;
      // blocked flag: set on any midpoint hit, cleared when a candidate starts
      if (s2_v && hit) blocked <= 1'b1;
      else if (state == S_CMP) blocked <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            unique case (q_item.mode)
              MODE_LOAD: begin
                if (count[CNT_W-1]) begin
                  single <= '{layer: 1'b0, from_index: '0, to_index: '0,
                              has_bond: 1'b0, last: 1'b1, status: ST_FULL};
                end else begin
                  single <= '{layer: 1'b0, from_index: IDX_W'(count), to_index: '0,
                              has_bond: 1'b0, last: 1'b1, status: ST_OK};
                  count <= count + 1'b1;
                end
                state <= S_ONE;
              end
              MODE_CLEAR: begin
                single <= '{layer: 1'b0, from_index: '0, to_index: '0,
                            has_bond: 1'b0, last: 1'b1, status: ST_OK};
                count <= '0;
                state <= S_ONE;
              end
              default: begin
                qi <= q_item.query_index;
                if (CNT_W'(q_item.query_index) >= count) begin
                  single <= '{layer: 1'b0, from_index: q_item.query_index, to_index: '0,
                              has_bond: 1'b0, last: 1'b1, status: ST_BADIDX};
                  state <= S_ONE;
                end else begin
                  state <= S_QA;
                end
              end
            endcase
          end
        end
        S_ONE: begin
          if (slot_free) begin
            out_r <= single;
            state <= S_IDLE;
          end
        end
        S_QA: state <= S_QB;
        S_QB: begin
          j      <= '0;
          n      <= '0;
          pend_v <= 1'b0;
          trunc  <= 1'b0;
          if (cfg.max_neighbors == '0)
            limit <= BOND_W'(1);
          else if (MAXN_W'(cfg.max_neighbors) > MAXN_W'(BOND_LIMIT))
            limit <= BOND_W'(BOND_LIMIT);
          else
            limit <= BOND_W'(cfg.max_neighbors);
          state <= S_RD;
        end
        S_RD: begin
          if (j >= count)                state <= S_FIN;
          else if (j == CNT_W'(qi))      j <= j + 1'b1;
          else                           state <= S_DIF;
        end
        S_DIF: state <= S_SQ;
        S_SQ:  state <= S_CMP;
        S_CMP: begin
          if (d2 < D2_W'(far2)) begin
            mk      <= '0;
            state   <= S_MID;
          end else begin
            j     <= j + 1'b1;
            state <= S_RD;
          end
        end
        S_MID: begin
          mk <= mk + 1'b1;
          if (mk == MK_W'(SUBDIVISIONS + 1)) state <= S_DEC;
        end
        S_DEC: begin
          if (blocked) begin
            j     <= j + 1'b1;
            state <= S_RD;
          end else if (n >= limit) begin
            trunc <= 1'b1;
            state <= S_FIN;
          end else if (pend_v) begin
            state <= S_PEND;
          end else begin
            pend_v     <= 1'b1;
            pend_layer <= !near_hit;
            pend_to    <= IDX_W'(j);
            n          <= n + 1'b1;
            j          <= j + 1'b1;
            state      <= S_RD;
          end
        end
        S_PEND: begin
          if (slot_free) begin
            out_r <= '{layer: pend_layer, from_index: qi, to_index: pend_to,
                       has_bond: 1'b1, last: 1'b0, status: ST_OK};
            pend_layer <= !near_hit;
            pend_to    <= IDX_W'(j);
            n          <= n + 1'b1;
            j          <= j + 1'b1;
            state      <= S_RD;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            if (pend_v)
              out_r <= '{layer: pend_layer, from_index: qi, to_index: pend_to,
                         has_bond: 1'b1, last: 1'b1,
                         status: (trunc ? ST_TRUNC : ST_OK)};
            else
              out_r <= '{layer: 1'b0, from_index: qi, to_index: '0,
                         has_bond: 1'b0, last: 1'b1, status: ST_OK};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/bond_neighbor_search_core.sv -----
// Load/clear: the item is taken from the queue head in S_IDLE and moved to the result register
// from S_ONE once the result slot is free; one item at a time. Query: setup in S_QA and S_QB,
// then per stored point S_RD, S_DIF, S_SQ and S_CMP, plus S_MID and S_DEC when it lies inside the
// far cutoff, paced by the single read port of the point store and the one-midpoint-per-cycle region checker.
// Reset restores the register defaults and empties the store (count 0); store
// contents are undefined until loaded, no clearing pass is run.
module bond_neighbor_search_core
  import bns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bns_in_if.sink      items,
  bns_out_if.source   results
);

  cfg_t       cfg;
  logic       q_valid;
  item_t      q_item;
  logic       q_pop;
  back_stat_t bstat;

  bns_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  bns_front u_front (
    .clk, .rst, .items, .q_valid, .q_item, .q_pop
  );

  bns_back u_back (
    .clk, .rst, .cfg, .q_valid, .q_item, .q_pop, .results, .stat(bstat)
  );

  // store never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bstat.count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  // back end only takes work that is queued, and only when idle
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_valid && !bstat.busy))
    else $error("queue pop without entry");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !results.valid)
    else $error("result valid after reset");

endmodule

// ----- dv/bns_checker.sv -----
// Result checker: watches the request channels and register writes, predicts bonds, compares.
`timescale 1ns / 1ps
module bns_checker
  import bns_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  bns_in_if           items,
  bns_out_if          results,
  output int          failures,
  output int          pending
);

  longint px [MAX_POINTS];
  longint py [MAX_POINTS];
  longint pz [MAX_POINTS];
  int unsigned n_points;
  logic [CUT_W-1:0]  near_lim;
  logic [CUT_W-1:0]  far_lim;
  logic [MAXN_W-1:0] bond_cap;
  result_t bonds_due [$];

  // append one expected result
  task automatic enqueue_due(result_t r);
    bonds_due.insert(bonds_due.size(), r);
  endtask

  function automatic bit hits_circle(longint mx, longint my, longint cx, longint cy,
                                     longint r);
    longint rs, dx, dy;
    rs = r * SCALE;
    dx = mx - cx * SCALE;
    dy = my - cy * SCALE;
    if (dx > rs || dx < -rs || dy > rs || dy < -rs) return 0;
    return dx * dx + dy * dy <= rs * rs;
  endfunction

  function automatic bit hits_notch(longint mx, longint my);
    longint u, v, av;
    u = mx - 32 * SCALE;
    v = my - 25 * SCALE;
    av = (v < 0) ? -v : v;
    if (25 * av > 26 * SCALE) return 0;
    if (u < 0) return 0;
    if (u >= 2 * SCALE) return 1;
    return 3 * v * v <= u * u;
  endfunction

  // every sub-segment midpoint must avoid the circles and the notch
  function automatic bit path_open(int unsigned a, int unsigned b);
    longint dx, dy, mx, my;
    dx = px[b] - px[a];
    dy = py[b] - py[a];
    for (int k = 0; k < SUBDIVISIONS; k++) begin
      mx = 2 * SUBDIVISIONS * px[a] + (2 * k + 1) * dx;
      my = 2 * SUBDIVISIONS * py[a] + (2 * k + 1) * dy;
      if (hits_circle(mx, my, 40, 14, 5) || hits_circle(mx, my, 40, 36, 5) ||
          hits_circle(mx, my, 18, 35, 4) || hits_notch(mx, my))
        return 0;
    end
    return 1;
  endfunction

  function automatic result_t mk(logic ly, logic [IDX_W-1:0] fr, logic [IDX_W-1:0] to,
                                 logic hb, logic ls, logic [1:0] st);
    result_t r;
    r.layer = ly; r.from_index = fr; r.to_index = to;
    r.has_bond = hb; r.last = ls; r.status = st;
    return r;
  endfunction

  // scan the store for bonds of one point
  task automatic predict_query(int unsigned qi);
    int unsigned lim, n;
    longint dx, dy, dz, d2, far2, near2;
    bit trunc;
    result_t found [$];
    if (qi >= n_points) begin
      enqueue_due(mk(1'b0, IDX_W'(qi), '0, 1'b0, 1'b1, ST_BADIDX));
      return;
    end
    lim = (bond_cap == 0) ? 1 : ((bond_cap > BOND_LIMIT) ? BOND_LIMIT : bond_cap);
    far2 = longint'(far_lim) * far_lim;
    near2 = longint'(near_lim) * near_lim;
    trunc = 0;
    n = 0;
    for (int unsigned j = 0; j < n_points; j++) begin
      if (j == qi) continue;
      dx = px[j] - px[qi];
      dy = py[j] - py[qi];
      dz = pz[j] - pz[qi];
      d2 = dx * dx + dy * dy + dz * dz;
      if (d2 >= far2 || !path_open(qi, j)) continue;
      if (n >= lim) begin
        trunc = 1;
        break;
      end
      found.insert(found.size(), mk(d2 < near2 ? 1'b0 : 1'b1, IDX_W'(qi), IDX_W'(j),
                                    1'b1, 1'b0, ST_OK));
      n++;
    end
    if (n == 0) begin
      enqueue_due(mk(1'b0, IDX_W'(qi), '0, 1'b0, 1'b1, ST_OK));
      return;
    end
    found[n-1].last = 1;
    if (trunc) found[n-1].status = ST_TRUNC;
    foreach (found[i]) enqueue_due(found[i]);
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      n_points = 0;
      near_lim = 16'd1324;
      far_lim = 16'd2293;
      bond_cap = 4'd12;
      failures <= 0;
      bonds_due.delete();
      pending <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_NEAR: near_lim = pwdata[CUT_W-1:0];
          REG_FAR:  far_lim = pwdata[CUT_W-1:0];
          REG_MAXN: bond_cap = pwdata[MAXN_W-1:0];
          default: ;
        endcase
      end
      // accepted input request
      if (items.valid && items.ready) begin
        case (items.mode)
          MODE_LOAD: begin
            if (n_points >= MAX_POINTS) begin
              enqueue_due(mk(1'b0, '0, '0, 1'b0, 1'b1, ST_FULL));
            end else begin
              px[n_points] = items.pos_x;
              py[n_points] = items.pos_y;
              pz[n_points] = items.pos_z;
              enqueue_due(mk(1'b0, IDX_W'(n_points), '0, 1'b0, 1'b1, ST_OK));
              n_points = n_points + 1;
            end
          end
          MODE_QUERY: predict_query(items.query_index);
          MODE_CLEAR: begin
            n_points = 0;
            enqueue_due(mk(1'b0, '0, '0, 1'b0, 1'b1, ST_OK));
          end
          default: ;
        endcase
      end
      // accepted result request
      if (results.valid && results.ready) begin
        got = mk(results.layer, results.from_index, results.to_index, results.has_bond,
                 results.last, results.status);
        if (bonds_due.size() == 0) begin
          if (failures < 10)
            $display("unexpected result: layer=%0d from=%0d to=%0d bond=%0d last=%0d st=%0d",
                     got.layer, got.from_index, got.to_index, got.has_bond, got.last,
                     got.status);
          failures <= failures + 1;
        end else begin
          want = bonds_due.pop_front();
          if (got != want) begin
            if (failures < 10) begin
              $write("mismatch: exp layer=%0d from=%0d to=%0d bond=%0d last=%0d st=%0d",
                     want.layer, want.from_index, want.to_index, want.has_bond,
                     want.last, want.status);
              $display(" | got layer=%0d from=%0d to=%0d bond=%0d last=%0d st=%0d",
                       got.layer, got.from_index, got.to_index, got.has_bond,
                       got.last, got.status);
            end
            failures <= failures + 1;
          end
        end
      end
      pending <= bonds_due.size();
    end
  end

endmodule

// ----- dv/bond_neighbor_search_core_test.sv -----
// Testbench top: clock, reset, register writes, point loads and queries, verdict.
`timescale 1ns / 1ps
module bond_neighbor_search_core_test;
  import bns_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          failures;
  int          pending;
  int          holdoff_asked;
  int          holdoff_done;

  bns_in_if  item_ch ();
  bns_out_if result_ch ();

  bond_neighbor_search_core uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .items(item_ch), .results(result_ch)
  );

  bns_checker chk (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .items(item_ch), .results(result_ch), .failures(failures), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure, with one long hold-off on request
  initial begin
    int lo;
    result_ch.ready <= 1'b0;
    holdoff_done = 0;
    forever begin
      if (holdoff_asked != holdoff_done) begin
        holdoff_done++;
        result_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end else begin
        lo = gap_len();
        if (lo > 0) begin
          result_ch.ready <= 1'b0;
          repeat (lo) @(posedge clk);
        end
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // offer one request and hold it until accepted
  task automatic send(logic [1:0] m, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                      logic [COORD_W-1:0] z, logic [IDX_W-1:0] qi, int gap);
    item_ch.valid <= 1'b1;
    item_ch.mode <= m;
    item_ch.pos_x <= x; item_ch.pos_y <= y; item_ch.pos_z <= z;
    item_ch.query_index <= qi;
    do @(posedge clk); while (!item_ch.ready);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_pt(longint x, longint y, longint z);
    send(MODE_LOAD, x, y, z, $urandom, gap_len());
  endtask

  task automatic query(int qi);
    send(MODE_QUERY, $urandom, $urandom, $urandom, qi, gap_len());
  endtask

  // let the checker count the last accepted request, then wait until all results are out
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // a point around a chosen spot, offset by up to spread raw steps (4096 steps per unit)
  function automatic longint near_spot(longint base, int spread);
    return base + $signed($urandom_range(0, 2 * spread)) - spread;
  endfunction

  initial begin
    longint cx, cy;
    int npts, nq;
    logic [31:0] phase_cfg [5][3];
    holdoff_asked = 0;
    rst = 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    item_ch.valid <= 1'b0; item_ch.mode <= MODE_LOAD;
    item_ch.pos_x <= '0; item_ch.pos_y <= '0; item_ch.pos_z <= '0;
    item_ch.query_index <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty store, extremes, a clear, a blocked path, an isolated point, ignored mode, out-of-range indexes
    query(0);
    load_pt(-524288, -524288, -524288);
    load_pt(524287, 524287, 524287);
    query(0);
    send(MODE_CLEAR, 0, 0, 0, 0, 1);
    load_pt(30 * 4096, 25 * 4096, 0);
    load_pt(30 * 4096 + 1000, 25 * 4096, 0);
    load_pt(30 * 4096 + 2000, 25 * 4096 + 100, 0);
    load_pt(40 * 4096, 19 * 4096 - 100, 0);
    load_pt(40 * 4096, 19 * 4096 + 1500, 0);
    load_pt(10 * 4096, 10 * 4096, 0);
    query(0); query(1); query(3); query(5);
    send(MODE_IGNORE, 0, 0, 0, 0, 0);
    query(4095);
    query(6);
    drain();

    // register settings per phase: near, far, bond limit
    phase_cfg[0] = '{32'd1324, 32'd2293, 32'd12};
    phase_cfg[1] = '{32'd0, 32'd65535, 32'd1};
    phase_cfg[2] = '{32'd65535, 32'd65535, 32'd0};
    phase_cfg[3] = '{32'd3000, 32'd5000, 32'd15};
    phase_cfg[4] = '{32'd1800, 32'd0, 32'd5};

    for (int ph = 0; ph < 5; ph++) begin
      reg_write(REG_NEAR, phase_cfg[ph][0]);
      reg_write(REG_FAR, phase_cfg[ph][1]);
      reg_write(REG_MAXN, phase_cfg[ph][2]);
      send(MODE_CLEAR, 0, 0, 0, 0, gap_len());
      // a cluster near the forbidden regions
      cx = $urandom_range(15, 45) * 4096;
      cy = $urandom_range(10, 40) * 4096;
      npts = $urandom_range(6, 14);
      for (int i = 0; i < npts; i++)
        load_pt(near_spot(cx, 6000), near_spot(cy, 6000), near_spot(0, 2000));
      if (ph == 1) begin
        // long result hold-off while queries keep coming
        holdoff_asked++;
      end
      nq = $urandom_range(14, 20);
      for (int i = 0; i < nq; i++) begin
        case ($urandom_range(0, 9))
          0: query($urandom_range(0, 4095));
          1: load_pt($signed($urandom_range(0, 1048575)) - 524288,
                     $signed($urandom_range(0, 1048575)) - 524288,
                     $signed($urandom_range(0, 1048575)) - 524288);
          2: load_pt(near_spot(cx, 3000), near_spot(cy, 3000), 0);
          3: send(MODE_IGNORE, $urandom, $urandom, $urandom, $urandom, gap_len());
          default: query($urandom_range(0, npts - 1));
        endcase
      end
      drain();
    end

    // back to the reset defaults before the final verdict
    reg_write(REG_NEAR, 32'd1324);
    reg_write(REG_FAR, 32'd2293);
    reg_write(REG_MAXN, 32'd12);
    drain();

    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
